// ===== src/mbg_pkg.sv =====
package mbg_pkg;

   localparam int CFG_W  = 7;
   localparam int INFO_W = 7;
   localparam int DIRS_W = 4;
   localparam int LINK_BIT = 4;
   localparam int PARENT_LSB = 5;
   localparam int MIN_SIDE = 3;
   localparam int CFG_RESET = 31;

   localparam logic [DIRS_W-1:0] ALL_DIRS = 4'hF;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_DRAW  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   localparam logic [2:0] STAT_READ     = 3'd0;
   localparam logic [2:0] STAT_REJECT   = 3'd1;
   localparam logic [2:0] STAT_CARVED   = 3'd2;
   localparam logic [2:0] STAT_BACK     = 3'd3;
   localparam logic [2:0] STAT_FINISHED = 3'd4;
   localparam logic [2:0] STAT_IDLE     = 3'd5;

   localparam logic [1:0] CODE_OUTSIDE = 2'd0;
   localparam logic [1:0] CODE_WALL    = 2'd1;
   localparam logic [1:0] CODE_OPEN    = 2'd2;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SWEEP,
      S_READ,
      S_DRAW_CHK,
      S_TGT_RD,
      S_TGT_CHK,
      S_BT_ISSUE,
      S_BT_CHK,
      S_RESP
   } mbg_state_type;

endpackage

// ===== src/maze_backtracker_generator_core.sv =====
// Sequence: start rewrites all MAX_SIDE grid rows, one grid row per cycle; a read in the
// grid after the first start reads cell memory; a draw while generating checks its node,
// may then check the target, then node read and check per backtrack step; others respond.
// Throughput: one transaction in flight; the next is accepted once the result is in the
// output register, even if the result has not been taken yet.
// Reset: control, walk (1,1) and 31 x 31 grid size set at once; memories keep contents,
// cells read as walls until the first start rewrites the grid.
module maze_backtracker_generator_core #(
   parameter int MAX_SIDE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // draw_dir[1:0], read_x[7:2], read_y[13:8]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // pos_x[5:0], pos_y[11:6], cell_code[13:12]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   input  logic        csr_wr_en,
   input  logic        csr_addr,
   input  logic [6:0]  csr_wdata
);

   localparam int CW        = $clog2(MAX_SIDE);
   localparam int SW        = $clog2(MAX_SIDE + 1);
   localparam int CMPW      = (SW > mbg_pkg::CFG_W) ? SW : mbg_pkg::CFG_W;
   localparam int NODE_SIDE = (MAX_SIDE + 1) / 2;
   localparam int NCW       = $clog2(NODE_SIDE);
   localparam int NROW_W    = NODE_SIDE * mbg_pkg::INFO_W;

   logic [mbg_pkg::CFG_W-1:0] grid_width_ff, grid_height_ff;
   mbg_pkg::mbg_state_type    state_ff, state_in;
   logic [CW-1:0]             sweep_row_ff, sweep_row_in;
   logic [CW-1:0]             walk_x_ff, walk_x_in, walk_y_ff, walk_y_in;
   logic [CW-1:0]             tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic                      generating_ff, generating_in;
   logic                      started_ff, started_in;
   logic [1:0]                dir_ff, dir_in;
   logic [5:0]                rx_ff, rx_in;
   logic [2:0]                status_ff, status_in;
   logic [1:0]                code_ff, code_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]               rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]                rsp_tuser_ff, rsp_tuser_in;

   logic [MAX_SIDE-1:0] cell_mem [MAX_SIDE];
   logic [NROW_W-1:0]   node_mem [NODE_SIDE];
   logic [MAX_SIDE-1:0] cell_rdata_ff;
   logic [NROW_W-1:0]   node_rdata_ff;

   logic                      cell_rd_en, cell_row_we, cell_bit_we;
   logic [CW-1:0]             cell_rd_addr, cell_wr_addr, cell_wr_bit;
   logic [MAX_SIDE-1:0]       cell_row_data;
   logic                      node_rd_en, node_row_we, node_slice_we;
   logic [NCW-1:0]            node_rd_addr, node_wr_addr, node_wr_col;
   logic [NROW_W-1:0]         node_row_data;
   logic [mbg_pkg::INFO_W-1:0] node_slice_data;

   logic [SW-1:0]   grid_w, grid_h;
   logic [CMPW-1:0] gw_ext, gh_ext;
   logic            req_acc;
   logic [1:0]      req_action, req_dir;
   logic [5:0]      req_rx, req_ry;
   logic            rx_in_grid;
   logic [mbg_pkg::INFO_W-1:0] cur_info, tgt_info, cur_clr;
   logic            draw_ok, back_ok;
   logic [CW-1:0]   draw_nx, draw_ny, back_nx, back_ny;
   logic [CW:0]     mid_x_sum, mid_y_sum;

   function automatic logic step2(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                  input logic [1:0] d, output logic [CW-1:0] nx,
                                  output logic [CW-1:0] ny);
      logic [CW:0] a;
      logic [CW:0] b;
      logic        ok;
      a  = {1'b0, x};
      b  = {1'b0, y};
      ok = 1'b1;
      case (d)
         mbg_pkg::DIR_RIGHT: a = a + (CW+1)'(2);
         mbg_pkg::DIR_DOWN:  b = b + (CW+1)'(2);
         mbg_pkg::DIR_LEFT: begin
            if (x < CW'(2)) ok = 1'b0;
            else a = a - (CW+1)'(2);
         end
         mbg_pkg::DIR_UP: begin
            if (y < CW'(2)) ok = 1'b0;
            else b = b - (CW+1)'(2);
         end
         default: ok = 1'b0;
      endcase
      if (a >= (CW+1)'(MAX_SIDE) || b >= (CW+1)'(MAX_SIDE)) ok = 1'b0;
      nx = a[CW-1:0];
      ny = b[CW-1:0];
      return ok;
   endfunction

   assign gw_ext = CMPW'(grid_width_ff);
   assign gh_ext = CMPW'(grid_height_ff);
   assign grid_w = (gw_ext > CMPW'(MAX_SIDE)) ? SW'(MAX_SIDE) :
                   (gw_ext < CMPW'(mbg_pkg::MIN_SIDE)) ? SW'(mbg_pkg::MIN_SIDE) : SW'(gw_ext);
   assign grid_h = (gh_ext > CMPW'(MAX_SIDE)) ? SW'(MAX_SIDE) :
                   (gh_ext < CMPW'(mbg_pkg::MIN_SIDE)) ? SW'(mbg_pkg::MIN_SIDE) : SW'(gh_ext);

   assign req_action = req_tuser;
   assign req_dir    = req_tdata[1:0];
   assign req_rx     = req_tdata[7:2];
   assign req_ry     = req_tdata[13:8];
   assign req_tready = (state_ff == mbg_pkg::S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rx_in_grid = (CMPW'(req_rx) < CMPW'(grid_w)) && (CMPW'(req_ry) < CMPW'(grid_h));

   assign cur_info = node_rdata_ff[NCW'(walk_x_ff >> 1) * mbg_pkg::INFO_W +: mbg_pkg::INFO_W];
   assign tgt_info = node_rdata_ff[NCW'(tgt_x_ff >> 1) * mbg_pkg::INFO_W +: mbg_pkg::INFO_W];
   assign cur_clr  = cur_info & ~mbg_pkg::INFO_W'(1 << dir_ff);
   assign mid_x_sum = {1'b0, walk_x_ff} + {1'b0, tgt_x_ff};
   assign mid_y_sum = {1'b0, walk_y_ff} + {1'b0, tgt_y_ff};

   always_comb begin
      draw_ok = step2(walk_x_ff, walk_y_ff, dir_ff, draw_nx, draw_ny);
      back_ok = step2(walk_x_ff, walk_y_ff, cur_info[mbg_pkg::PARENT_LSB +: 2],
                      back_nx, back_ny);
   end

   always_comb begin
      int x;
      int c;
      logic row_on;
      row_on = sweep_row_ff[0] && (SW'(sweep_row_ff) < grid_h);
      for (x = 0; x < MAX_SIDE; x++) begin
         cell_row_data[x] = row_on && ((x % 2) == 1) && (SW'(x) < grid_w);
      end
      for (c = 0; c < NODE_SIDE; c++) begin
         node_row_data[c*mbg_pkg::INFO_W +: mbg_pkg::INFO_W] =
            (row_on && (SW'(2*c+1) < grid_w)) ?
            mbg_pkg::INFO_W'(mbg_pkg::ALL_DIRS) : '0;
      end
      if (sweep_row_ff == CW'(1)) begin
         node_row_data[mbg_pkg::LINK_BIT] = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sweep_row_in  = sweep_row_ff;
      walk_x_in     = walk_x_ff;
      walk_y_in     = walk_y_ff;
      tgt_x_in      = tgt_x_ff;
      tgt_y_in      = tgt_y_ff;
      generating_in = generating_ff;
      started_in    = started_ff;
      dir_in        = dir_ff;
      rx_in         = rx_ff;
      status_in     = status_ff;
      code_in       = code_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      cell_rd_en      = 1'b0;
      cell_rd_addr    = '0;
      cell_row_we     = 1'b0;
      cell_bit_we     = 1'b0;
      cell_wr_addr    = '0;
      cell_wr_bit     = '0;
      node_rd_en      = 1'b0;
      node_rd_addr    = '0;
      node_row_we     = 1'b0;
      node_slice_we   = 1'b0;
      node_wr_addr    = '0;
      node_wr_col     = '0;
      node_slice_data = '0;

      case (state_ff)
         mbg_pkg::S_IDLE: begin
            if (req_acc) begin
               dir_in    = req_dir;
               rx_in     = req_rx;
               status_in = mbg_pkg::STAT_IDLE;
               code_in   = mbg_pkg::CODE_OUTSIDE;
               state_in  = mbg_pkg::S_RESP;
               case (req_action)
                  mbg_pkg::ACT_START: begin
                     sweep_row_in = '0;
                     state_in     = mbg_pkg::S_SWEEP;
                  end
                  mbg_pkg::ACT_DRAW: begin
                     if (generating_ff) begin
                        node_rd_en   = 1'b1;
                        node_rd_addr = NCW'(walk_y_ff >> 1);
                        state_in     = mbg_pkg::S_DRAW_CHK;
                     end
                  end
                  mbg_pkg::ACT_READ: begin
                     status_in = mbg_pkg::STAT_READ;
                     if (rx_in_grid) begin
                        if (started_ff) begin
                           cell_rd_en   = 1'b1;
                           cell_rd_addr = CW'(req_ry);
                           state_in     = mbg_pkg::S_READ;
                        end else begin
                           code_in = mbg_pkg::CODE_WALL;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         mbg_pkg::S_SWEEP: begin
            cell_row_we  = 1'b1;
            cell_wr_addr = sweep_row_ff;
            node_row_we  = sweep_row_ff[0];
            node_wr_addr = NCW'(sweep_row_ff >> 1);
            sweep_row_in = sweep_row_ff + CW'(1);
            if (sweep_row_ff == CW'(MAX_SIDE - 1)) begin
               walk_x_in     = CW'(1);
               walk_y_in     = CW'(1);
               generating_in = 1'b1;
               started_in    = 1'b1;
               state_in      = mbg_pkg::S_RESP;
            end
         end
         mbg_pkg::S_READ: begin
            code_in  = cell_rdata_ff[CW'(rx_ff)] ? mbg_pkg::CODE_OPEN : mbg_pkg::CODE_WALL;
            state_in = mbg_pkg::S_RESP;
         end
         mbg_pkg::S_DRAW_CHK: begin
            node_slice_we   = 1'b1;
            node_wr_addr    = NCW'(walk_y_ff >> 1);
            node_wr_col     = NCW'(walk_x_ff >> 1);
            node_slice_data = cur_clr;
            tgt_x_in        = draw_nx;
            tgt_y_in        = draw_ny;
            if (cur_info[dir_ff] && draw_ok && (SW'(draw_nx) < grid_w) &&
                (SW'(draw_ny) < grid_h)) begin
               state_in = mbg_pkg::S_TGT_RD;
            end else begin
               status_in = mbg_pkg::STAT_REJECT;
               state_in  = mbg_pkg::S_BT_ISSUE;
            end
         end
         mbg_pkg::S_TGT_RD: begin
            cell_rd_en   = 1'b1;
            cell_rd_addr = tgt_y_ff;
            node_rd_en   = 1'b1;
            node_rd_addr = NCW'(tgt_y_ff >> 1);
            state_in     = mbg_pkg::S_TGT_CHK;
         end
         mbg_pkg::S_TGT_CHK: begin
            state_in = mbg_pkg::S_BT_ISSUE;
            if (cell_rdata_ff[tgt_x_ff] && !tgt_info[mbg_pkg::LINK_BIT]) begin
               node_slice_we   = 1'b1;
               node_wr_addr    = NCW'(tgt_y_ff >> 1);
               node_wr_col     = NCW'(tgt_x_ff >> 1);
               node_slice_data = {dir_ff ^ mbg_pkg::DIR_LEFT, 1'b1,
                                  tgt_info[mbg_pkg::DIRS_W-1:0]};
               cell_bit_we     = 1'b1;
               cell_wr_addr    = mid_y_sum[CW:1];
               cell_wr_bit     = mid_x_sum[CW:1];
               walk_x_in       = tgt_x_ff;
               walk_y_in       = tgt_y_ff;
               status_in       = mbg_pkg::STAT_CARVED;
            end else begin
               status_in = mbg_pkg::STAT_REJECT;
            end
         end
         mbg_pkg::S_BT_ISSUE: begin
            node_rd_en   = 1'b1;
            node_rd_addr = NCW'(walk_y_ff >> 1);
            state_in     = mbg_pkg::S_BT_CHK;
         end
         mbg_pkg::S_BT_CHK: begin
            state_in = mbg_pkg::S_RESP;
            if (cur_info[mbg_pkg::DIRS_W-1:0] == '0) begin
               if ((walk_x_ff == CW'(1) && walk_y_ff == CW'(1)) || !back_ok) begin
                  generating_in = 1'b0;
                  status_in     = mbg_pkg::STAT_FINISHED;
               end else begin
                  walk_x_in = back_nx;
                  walk_y_in = back_ny;
                  if (back_nx == CW'(1) && back_ny == CW'(1)) begin
                     generating_in = 1'b0;
                     status_in     = mbg_pkg::STAT_FINISHED;
                  end else begin
                     status_in = mbg_pkg::STAT_BACK;
                     state_in  = mbg_pkg::S_BT_ISSUE;
                  end
               end
            end
         end
         mbg_pkg::S_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, code_ff, 6'(walk_y_ff), 6'(walk_x_ff)};
               rsp_tuser_in  = status_ff;
               state_in      = mbg_pkg::S_IDLE;
            end
         end
         default: state_in = mbg_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mbg_pkg::S_IDLE;
         walk_x_ff      <= CW'(1);
         walk_y_ff      <= CW'(1);
         generating_ff  <= 1'b0;
         started_ff     <= 1'b0;
         status_ff      <= mbg_pkg::STAT_IDLE;
         rsp_tvalid_ff  <= 1'b0;
         grid_width_ff  <= mbg_pkg::CFG_W'(mbg_pkg::CFG_RESET);
         grid_height_ff <= mbg_pkg::CFG_W'(mbg_pkg::CFG_RESET);
      end else begin
         state_ff      <= state_in;
         walk_x_ff     <= walk_x_in;
         walk_y_ff     <= walk_y_in;
         generating_ff <= generating_in;
         started_ff    <= started_in;
         status_ff     <= status_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            case (csr_addr)
               mbg_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
               mbg_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sweep_row_ff <= sweep_row_in;
      tgt_x_ff     <= tgt_x_in;
      tgt_y_ff     <= tgt_y_in;
      dir_ff       <= dir_in;
      rx_ff        <= rx_in;
      code_ff      <= code_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   always_ff @(posedge clock) begin
      if (cell_rd_en) cell_rdata_ff <= cell_mem[cell_rd_addr];
      if (cell_row_we) begin
         cell_mem[cell_wr_addr] <= cell_row_data;
      end else if (cell_bit_we) begin
         cell_mem[cell_wr_addr][cell_wr_bit] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (node_rd_en) node_rdata_ff <= node_mem[node_rd_addr];
      if (node_row_we) begin
         node_mem[node_wr_addr] <= node_row_data;
      end else if (node_slice_we) begin
         node_mem[node_wr_addr][node_wr_col * mbg_pkg::INFO_W +: mbg_pkg::INFO_W] <=
            node_slice_data;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_walk_on_node: assert property (@(posedge clock) disable iff (reset)
      generating_ff |-> (walk_x_ff[0] && walk_y_ff[0]))
      else $error("walk left the node lattice");

   a_start_sweeps: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_action == mbg_pkg::ACT_START) |=>
      (state_ff == mbg_pkg::S_SWEEP && sweep_row_ff == '0))
      else $error("start did not begin the grid sweep");

   a_finish_status: assert property (@(posedge clock) disable iff (reset)
      $fell(generating_ff) |-> (status_ff == mbg_pkg::STAT_FINISHED))
      else $error("generation ended without finished status");

   a_gen_after_start: assert property (@(posedge clock) disable iff (reset)
      generating_ff |-> started_ff)
      else $error("generating before any start");

   a_carve_while_gen: assert property (@(posedge clock) disable iff (reset)
      (cell_bit_we || node_slice_we) |-> generating_ff)
      else $error("maze memory modified outside generation");

endmodule
